// File: rtl/pras_pkg.sv
// Shared types and constants for the probabilistic ring automaton step block.
package pras_pkg;

  localparam int DEFAULT_MAX_CELLS = 1024;
  localparam int MIN_CELLS         = 3;
  localparam int CNT_W             = 11;
  localparam int GEN_W             = 32;
  localparam int CFG_W             = 11;
  localparam int RESET_RING_LENGTH = 1024;

  // request kinds
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_UPDATE = 1'b1
  } req_kind_t;

  // rule selection
  typedef enum logic {
    MODE_ALPHA      = 1'b0,
    MODE_ALPHA_BETA = 1'b1
  } rule_mode_t;

  // configuration register indexes
  typedef enum logic {
    REG_RING_LENGTH = 1'b0,
    REG_RULE_MODE   = 1'b1
  } cfg_reg_t;

  // one input request
  typedef struct packed {
    req_kind_t req_type;
    logic      init_value;
    logic      alpha_flip;
    logic      beta_flip;
  } in_req_t;

  // one generation result
  typedef struct packed {
    logic [GEN_W-1:0] generation_index;
    logic [CNT_W-1:0] ones_count;
    logic [CNT_W-1:0] zeros_count;
    logic [CNT_W-1:0] pairs_zero_zero;
    logic [CNT_W-1:0] pairs_zero_one;
    logic [CNT_W-1:0] pairs_one_zero;
    logic [CNT_W-1:0] pairs_one_one;
  } out_res_t;

  // control from the update stage to the statistics unit
  typedef struct packed {
    logic fire;   // stage holds a request that completes this cycle
    logic load;   // request is a load
    logic first;  // cell index 0
    logic last;   // last cell of the ring
    logic nv;     // new cell value (updates)
    logic clr;    // ring length written: drop tallies
  } stats_ctl_t;

endpackage

// File: rtl/probabilistic_ring_automaton_step.sv
// Top level: cell memory, sweep pointer, update stage and result register.
// A result is registered when the last cell's update leaves the update stage.
// One request per cycle unless stalled; only a held result blocks a finished generation.
// Reset and every ring_length write stall the input for one cycle while the wrap-around
// neighbor (last cell) is fetched from cell memory. Cell memory is not cleared;
// reset clears pointer, tallies, generation counter and carried cells.
module probabilistic_ring_automaton_step #(
  parameter int MAX_CELLS = pras_pkg::DEFAULT_MAX_CELLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pras_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pras_pkg::out_res_t           out_data,
  input  logic                         cfg_we,
  input  pras_pkg::cfg_reg_t           cfg_idx,
  input  logic [pras_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(MAX_CELLS);
  localparam int LEN_W = $clog2(MAX_CELLS + 1);

  // saturate a written length to the supported range
  function automatic logic [LEN_W-1:0] eff_len(input logic [pras_pkg::CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'(pras_pkg::MIN_CELLS)) w = 32'(pras_pkg::MIN_CELLS);
    if (w > 32'(MAX_CELLS)) w = 32'(MAX_CELLS);
    return LEN_W'(w);
  endfunction

  logic                 mem [MAX_CELLS];

  logic [LEN_W-1:0]     len_eff_r;
  logic [PTR_W-1:0]     last_idx_r;
  pras_pkg::rule_mode_t mode_r;
  logic [LEN_W-1:0]     cfg_len;
  logic [LEN_W-1:0]     cfg_len_m1;

  logic                 refetch_r;
  logic                 fill_r;
  logic [PTR_W-1:0]     ptr_r;
  logic [PTR_W-1:0]     ptr_nxt;
  logic [PTR_W-1:0]     addr_b;
  logic                 rd_a_r;
  logic                 rd_b_r;
  logic                 l0_r;
  logic                 old_first_r;
  logic                 old_prev_r;

  logic                 v1_r;
  pras_pkg::in_req_t    req1_r;
  logic                 first1_r;
  logic                 last1_r;
  logic [PTR_W-1:0]     addr1_r;

  logic                 len_wr;
  logic                 in_accept;
  logic                 is_upd;
  logic                 emits;
  logic                 s1_go;
  logic                 s1_fire;
  logic                 l_val;
  logic                 r_val;
  logic                 nv;
  logic                 wd;

  logic                 out_valid_r;
  pras_pkg::out_res_t   out_data_r;
  pras_pkg::out_res_t   res;
  pras_pkg::stats_ctl_t sctl;

  // configuration registers
  assign len_wr     = cfg_we && (cfg_idx == pras_pkg::REG_RING_LENGTH);
  assign cfg_len    = eff_len(cfg_wdata);
  assign cfg_len_m1 = cfg_len - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_eff_r  <= eff_len(pras_pkg::CFG_W'(pras_pkg::RESET_RING_LENGTH));
      last_idx_r <= PTR_W'(eff_len(pras_pkg::CFG_W'(pras_pkg::RESET_RING_LENGTH))
                           - LEN_W'(1));
      mode_r     <= pras_pkg::MODE_ALPHA;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pras_pkg::REG_RING_LENGTH: begin
          len_eff_r  <= cfg_len;
          last_idx_r <= PTR_W'(cfg_len_m1);
        end
        pras_pkg::REG_RULE_MODE: begin
          mode_r <= pras_pkg::rule_mode_t'(cfg_wdata[0]);
        end
        default: ;
      endcase
    end
  end

  // handshake
  assign is_upd    = (req1_r.req_type == pras_pkg::REQ_UPDATE);
  assign emits     = v1_r && is_upd && last1_r;
  assign s1_go     = !emits || !out_valid_r || !out_stall;
  assign s1_fire   = v1_r && s1_go;
  assign in_stall  = refetch_r || (v1_r && !s1_go);
  assign in_accept = in_valid && !in_stall;

  // fetch of the last cell after reset or a length change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refetch_r <= 1'b1;
      fill_r    <= 1'b0;
    end else begin
      refetch_r <= len_wr;
      fill_r    <= refetch_r;
    end
  end

  // sweep pointer
  assign ptr_nxt = (ptr_r == last_idx_r) ? '0 : ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (len_wr) begin
      ptr_r <= '0;
    end else if (in_accept) begin
      ptr_r <= ptr_nxt;
    end
  end

  // read port B: right neighbor, or the last cell during a fetch
  always_comb begin
    if (refetch_r || (ptr_r == last_idx_r)) begin
      addr_b = last_idx_r;
    end else begin
      addr_b = ptr_r + PTR_W'(1);
    end
  end

  // cell memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[addr1_r] <= wd;
    end
    if (in_accept) begin
      rd_a_r <= mem[ptr_r];
    end
    if (in_accept || refetch_r) begin
      rd_b_r <= mem[addr_b];
    end
  end

  // update stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_fire || !v1_r) begin
      v1_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req1_r   <= in_data;
      first1_r <= (ptr_r == '0);
      last1_r  <= (ptr_r == last_idx_r);
      addr1_r  <= ptr_r;
    end
  end

  // neighbors from the old generation
  assign l_val = first1_r ? l0_r : old_prev_r;
  assign r_val = last1_r ? old_first_r : rd_b_r;

  pras_rule u_rule (
    .mode  (mode_r),
    .l     (l_val),
    .s     (rd_a_r),
    .r     (r_val),
    .alpha (req1_r.alpha_flip),
    .beta  (req1_r.beta_flip),
    .nv    (nv)
  );

  assign wd = is_upd ? nv : req1_r.init_value;

  // carried old cells, and the last cell as seen by cell zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_first_r <= 1'b0;
      old_prev_r  <= 1'b0;
      l0_r        <= 1'b0;
    end else begin
      if (s1_fire && is_upd) begin
        old_prev_r <= rd_a_r;
        if (first1_r) begin
          old_first_r <= rd_a_r;
        end
      end
      if (fill_r) begin
        l0_r <= rd_b_r;
      end else if (s1_fire && last1_r) begin
        l0_r <= wd;
      end
    end
  end

  // statistics
  always_comb begin
    sctl.fire  = s1_fire;
    sctl.load  = !is_upd;
    sctl.first = first1_r;
    sctl.last  = last1_r;
    sctl.nv    = nv;
    sctl.clr   = len_wr;
  end

  pras_stats #(
    .MAX_CELLS (MAX_CELLS)
  ) u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sctl),
    .len_eff (len_eff_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emits) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emits) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/pras_rule.sv
// Cell update rule: new value from left, self, right and the random events.
module pras_rule (
  input  pras_pkg::rule_mode_t mode,
  input  logic                 l,
  input  logic                 s,
  input  logic                 r,
  input  logic                 alpha,
  input  logic                 beta,
  output logic                 nv
);

  logic ap0;
  logic ap1;

  // alpha results for the two modes
  assign ap0 = (~s & (l | r)) | (l & r);
  assign ap1 = (~s & (l ^ r)) | (l & r);

  always_comb begin
    unique case (mode)
      pras_pkg::MODE_ALPHA: begin
        nv = alpha ? ap0 : s;
      end
      pras_pkg::MODE_ALPHA_BETA: begin
        // both events saturate to the OR of their results
        if (alpha || beta) begin
          nv = (alpha & ap1) | (beta & r);
        end else begin
          nv = s;
        end
      end
      default: nv = s;
    endcase
  end

endmodule

// File: rtl/pras_stats.sv
// Generation statistics: ones and neighbor pair tallies, generation counter.
module pras_stats #(
  parameter int MAX_CELLS = pras_pkg::DEFAULT_MAX_CELLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pras_pkg::stats_ctl_t                ctl,
  input  logic [$clog2(MAX_CELLS+1)-1:0]      len_eff,
  output pras_pkg::out_res_t                  res
);

  localparam int LEN_W = $clog2(MAX_CELLS + 1);
  localparam int ZW    = (LEN_W > pras_pkg::CNT_W) ? LEN_W : pras_pkg::CNT_W;

  logic [pras_pkg::CNT_W-1:0] ones_r;
  logic [pras_pkg::CNT_W-1:0] ones_nxt;
  logic [pras_pkg::CNT_W-1:0] pair_r   [4];
  logic [pras_pkg::CNT_W-1:0] pair_nxt [4];
  logic [pras_pkg::GEN_W-1:0] gen_r;
  logic [pras_pkg::GEN_W-1:0] gen_nxt;
  logic                       new_first_r;
  logic                       new_prev_r;
  logic                       upd;
  logic                       inc_a;
  logic                       inc_b;
  logic [1:0]                 idx_a;
  logic [1:0]                 idx_b;
  logic [ZW-1:0]              ones_z;
  logic [ZW-1:0]              len_z;
  logic [ZW-1:0]              zeros_z;

  assign upd   = ctl.fire & (ctl.load == 1'b0);
  // pair ending at this cell, and the wrap pair closing the ring
  assign inc_a = upd & ~ctl.first;
  assign inc_b = upd & ctl.last;
  assign idx_a = {new_prev_r, ctl.nv};
  assign idx_b = {ctl.nv, new_first_r};

  // tallies including the current cell
  always_comb begin
    ones_nxt = ones_r + pras_pkg::CNT_W'(ctl.nv);
    gen_nxt  = gen_r + pras_pkg::GEN_W'(1);
    for (int k = 0; k < 4; k++) begin
      pair_nxt[k] = pair_r[k]
                  + pras_pkg::CNT_W'(inc_a && (idx_a == 2'(k)))
                  + pras_pkg::CNT_W'(inc_b && (idx_b == 2'(k)));
    end
  end

  // zeros: length minus ones, floored at zero
  always_comb begin
    ones_z  = ZW'(ones_nxt);
    len_z   = ZW'(len_eff);
    zeros_z = (ones_z <= len_z) ? (len_z - ones_z) : '0;
  end

  always_comb begin
    res.generation_index = gen_nxt;
    res.ones_count       = ones_nxt;
    res.zeros_count      = pras_pkg::CNT_W'(zeros_z);
    res.pairs_zero_zero  = pair_nxt[0];
    res.pairs_zero_one   = pair_nxt[1];
    res.pairs_one_zero   = pair_nxt[2];
    res.pairs_one_one    = pair_nxt[3];
  end

  // tally registers; cleared whenever the sweep wraps or the ring length is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r <= '0;
      for (int k = 0; k < 4; k++) begin
        pair_r[k] <= '0;
      end
    end else if (ctl.clr || (ctl.fire && ctl.last)) begin
      ones_r <= '0;
      for (int k = 0; k < 4; k++) begin
        pair_r[k] <= '0;
      end
    end else if (upd) begin
      ones_r <= ones_nxt;
      for (int k = 0; k < 4; k++) begin
        pair_r[k] <= pair_nxt[k];
      end
    end
  end

  // generation counter and carried new-generation cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= '0;
      new_first_r <= 1'b0;
      new_prev_r  <= 1'b0;
    end else begin
      if (ctl.fire && ctl.load) begin
        gen_r <= '0;
      end else if (upd && ctl.last) begin
        gen_r <= gen_nxt;
      end
      if (upd) begin
        new_prev_r <= ctl.nv;
        if (ctl.first) begin
          new_first_r <= ctl.nv;
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
// Testbench for probabilistic_ring_automaton_step: ring sweeps checked against a local predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int          RING_CELLS    = pras_pkg::DEFAULT_MAX_CELLS;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          RESET_LOADS   = 8;
  localparam int          RANDOM_ITEMS  = 360;
  localparam int          HOLD_CYCLES   = 400;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  pras_pkg::in_req_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pras_pkg::out_res_t            out_data;
  logic                          cfg_we    = 1'b0;
  pras_pkg::cfg_reg_t            cfg_idx   = pras_pkg::REG_RING_LENGTH;
  logic [pras_pkg::CFG_W-1:0]    cfg_wdata = '0;

  // predicted ring state and register copies
  bit                            ring_cell    [RING_CELLS];
  bit                            cell_written [RING_CELLS];
  int unsigned                   cell_ptr     = 0;
  bit                            old_first    = 1'b0;
  bit                            old_prev     = 1'b0;
  bit                            new_first    = 1'b0;
  bit                            new_prev     = 1'b0;
  int unsigned                   ones_tally   = 0;
  int unsigned                   pair_tally   [4];
  bit [pras_pkg::GEN_W-1:0]      gen_count    = '0;
  bit [pras_pkg::CFG_W-1:0]      ring_len_reg = pras_pkg::CFG_W'(pras_pkg::RESET_RING_LENGTH);
  pras_pkg::rule_mode_t          mode_reg     = pras_pkg::MODE_ALPHA;

  pras_pkg::out_res_t            expected_stats[$];
  int unsigned                   items_sent   = 0;
  int unsigned                   results_seen = 0;
  int unsigned                   fail_count   = 0;
  int unsigned                   burst_left   = 0;
  int unsigned                   hold_request = 0;

  probabilistic_ring_automaton_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // length in use, saturated to the supported range
  function automatic int unsigned ring_span();
    if (ring_len_reg < pras_pkg::MIN_CELLS) return pras_pkg::MIN_CELLS;
    if (ring_len_reg > RING_CELLS) return RING_CELLS;
    return 32'(ring_len_reg);
  endfunction

  function automatic void clear_tallies();
    ones_tally = 0;
    foreach (pair_tally[k]) pair_tally[k] = 0;
  endfunction

  // pointer wrap starts a new set of tallies
  function automatic void advance_ptr(int unsigned p, int unsigned len);
    if (p + 1 >= len) begin
      cell_ptr = 0;
      clear_tallies();
    end else begin
      cell_ptr = p + 1;
    end
  endfunction

  // an update at the pointer must only read cells that hold a written value
  function automatic bit update_reads_loaded();
    int unsigned len, p;
    len = ring_span();
    p   = (cell_ptr >= len) ? 0 : cell_ptr;
    return cell_written[p] && (p == len - 1 || cell_written[p + 1]) &&
           (p != 0 || cell_written[len - 1]);
  endfunction

  // apply one accepted request; a finished generation queues its statistics
  task automatic predict_request(input pras_pkg::in_req_t req);
    int unsigned        len, p, ones;
    bit                 l, s, r, nv, rule_out;
    pras_pkg::out_res_t res;
    len = ring_span();
    p   = (cell_ptr >= len) ? 0 : cell_ptr;
    if (req.req_type == pras_pkg::REQ_LOAD) begin
      ring_cell[p]    = req.init_value;
      cell_written[p] = 1'b1;
      gen_count       = '0;
      advance_ptr(p, len);
    end else begin
      s = ring_cell[p];
      r = (p == len - 1) ? old_first : ring_cell[p + 1];
      l = (p == 0) ? ring_cell[len - 1] : old_prev;
      if (mode_reg == pras_pkg::MODE_ALPHA) begin
        rule_out = (!s & (l | r)) | (l & r);
        nv = req.alpha_flip ? rule_out : s;
      end else begin
        rule_out = (!s & (l ^ r)) | (l & r);
        // both events together saturate to the OR of their outcomes
        if (req.alpha_flip || req.beta_flip)
          nv = (req.alpha_flip & rule_out) | (req.beta_flip & r);
        else
          nv = s;
      end
      if (p == 0) begin
        old_first = s;
        new_first = nv;
      end else begin
        pair_tally[{new_prev, nv}]++;
      end
      ones_tally += nv;
      old_prev     = s;
      new_prev     = nv;
      ring_cell[p] = nv;
      if (p == len - 1) begin
        // closing pair wraps from the last cell to cell 0
        pair_tally[{nv, new_first}]++;
        gen_count++;
        ones = ones_tally & 32'h7FF;
        res.generation_index = gen_count;
        res.ones_count       = pras_pkg::CNT_W'(ones);
        res.zeros_count      = pras_pkg::CNT_W'((ones <= len) ? len - ones : 0);
        res.pairs_zero_zero  = pras_pkg::CNT_W'(pair_tally[0]);
        res.pairs_zero_one   = pras_pkg::CNT_W'(pair_tally[1]);
        res.pairs_one_zero   = pras_pkg::CNT_W'(pair_tally[2]);
        res.pairs_one_one    = pras_pkg::CNT_W'(pair_tally[3]);
        expected_stats.push_back(res);
      end
      advance_ptr(p, len);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  function automatic pras_pkg::in_req_t load_req(bit value);
    pras_pkg::in_req_t q;
    q.req_type   = pras_pkg::REQ_LOAD;
    q.init_value = value;
    q.alpha_flip = 1'($urandom_range(0, 1));
    q.beta_flip  = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic pras_pkg::in_req_t update_req(bit alpha, bit beta);
    pras_pkg::in_req_t q;
    q.req_type   = pras_pkg::REQ_UPDATE;
    q.init_value = 1'($urandom_range(0, 1));
    q.alpha_flip = alpha;
    q.beta_flip  = beta;
    return q;
  endfunction

  // offer one request in bursts with random gaps, wait for the handshake
  task automatic send_request(input pras_pkg::in_req_t req);
    int unsigned gap;
    if (req.req_type == pras_pkg::REQ_UPDATE && !update_reads_loaded())
      req = load_req(1'($urandom_range(0, 1)));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_request(req);
    items_sent++;
  endtask

  // stop offering, let every expected result out and the pipeline drain
  task automatic settle_block();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pras_pkg::cfg_reg_t idx,
                           input logic [pras_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pras_pkg::REG_RING_LENGTH: begin
        ring_len_reg = value;
        cell_ptr     = 0;
        clear_tallies();
      end
      pras_pkg::REG_RULE_MODE: mode_reg = pras_pkg::rule_mode_t'(value[0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  // stall pattern is redrawn from four styles at intervals; a long hold-off can be requested
  initial begin : result_sink
    int unsigned style = 0;
    int unsigned cyc   = 0;
    int unsigned hold  = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
      end
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      cyc++;
      if (hold != 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 7) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (cyc % 5) < 2;
        endcase
      end
    end
  end

  task automatic check_field(input string field, input logic [pras_pkg::GEN_W-1:0] want,
                             input logic [pras_pkg::GEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_check
    pras_pkg::out_res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result: expected none, got generation %0d",
                   $time, out_data.generation_index);
          fail_count++;
        end else begin
          want = expected_stats.pop_front();
          results_seen++;
          check_field("generation_index", want.generation_index,
                      out_data.generation_index);
          check_field("ones_count", pras_pkg::GEN_W'(want.ones_count),
                      pras_pkg::GEN_W'(out_data.ones_count));
          check_field("zeros_count", pras_pkg::GEN_W'(want.zeros_count),
                      pras_pkg::GEN_W'(out_data.zeros_count));
          check_field("pairs_zero_zero", pras_pkg::GEN_W'(want.pairs_zero_zero),
                      pras_pkg::GEN_W'(out_data.pairs_zero_zero));
          check_field("pairs_zero_one", pras_pkg::GEN_W'(want.pairs_zero_one),
                      pras_pkg::GEN_W'(out_data.pairs_zero_one));
          check_field("pairs_one_zero", pras_pkg::GEN_W'(want.pairs_one_zero),
                      pras_pkg::GEN_W'(out_data.pairs_one_zero));
          check_field("pairs_one_one", pras_pkg::GEN_W'(want.pairs_one_one),
                      pras_pkg::GEN_W'(out_data.pairs_one_one));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset length and rule: loads walk into the full-size ring and produce no result
  task automatic test_reset_length();
    repeat (RESET_LOADS) send_request(load_req(1'($urandom_range(0, 1))));
    settle_block();
    write_reg(pras_pkg::REG_RULE_MODE, pras_pkg::CFG_W'(pras_pkg::MODE_ALPHA_BETA));
    write_reg(pras_pkg::REG_RING_LENGTH, 11'h7FF);   // above range: full ring
    repeat (RESET_LOADS) send_request(load_req(1'($urandom_range(0, 1))));
  endtask

  // three-cell ring through both rules, each event combination and a mixed sweep
  task automatic test_small_ring_rules();
    settle_block();
    write_reg(pras_pkg::REG_RULE_MODE, pras_pkg::CFG_W'(pras_pkg::MODE_ALPHA));
    write_reg(pras_pkg::REG_RING_LENGTH, '0);        // below range: three cells
    send_request(load_req(1'b1));
    send_request(load_req(1'b0));
    send_request(load_req(1'b0));
    repeat (3) send_request(update_req(1'b1, 1'b1));   // beta ignored under alpha rule
    repeat (3) send_request(update_req(1'b0, 1'b0));   // nothing fires: cells hold
    settle_block();
    write_reg(pras_pkg::REG_RULE_MODE, pras_pkg::CFG_W'(pras_pkg::MODE_ALPHA_BETA));
    write_reg(pras_pkg::REG_RING_LENGTH, 11'd2);
    send_request(update_req(1'b1, 1'b0));
    send_request(update_req(1'b0, 1'b1));
    send_request(update_req(1'b1, 1'b1));
    repeat (3) send_request(update_req(1'b0, 1'b0));
    // load inside a sweep: generation count restarts, sweep carries on
    send_request(load_req(1'b1));
    send_request(update_req(1'b1, 1'b1));
    send_request(update_req(1'b0, 1'b1));
    settle_block();
    write_reg(pras_pkg::REG_RING_LENGTH, 11'd1);
    repeat (3) send_request(update_req(1'b1, 1'b0));
  endtask

  // hold the result side off while requests keep coming, so the input backs up
  task automatic test_result_backpressure();
    settle_block();
    write_reg(pras_pkg::REG_RING_LENGTH, 11'd3);
    repeat (3) send_request(load_req(1'($urandom_range(0, 1))));
    hold_request = HOLD_CYCLES;
    repeat (90) send_request(update_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // phases of random length and rule: usually load the ring, then sweeps with some noise
  task automatic test_random_sweeps();
    int unsigned item_goal, len, sweeps, a_odds, b_odds;
    item_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < item_goal) begin
      settle_block();
      case ($urandom_range(0, 7))
        0:       len = $urandom_range(0, 2);
        1:       len = $urandom_range(17, 64);
        default: len = $urandom_range(3, 16);
      endcase
      write_reg(pras_pkg::REG_RING_LENGTH, pras_pkg::CFG_W'(len));
      write_reg(pras_pkg::REG_RULE_MODE, pras_pkg::CFG_W'($urandom_range(0, 1)));
      len = ring_span();
      if ($urandom_range(0, 3) != 0)
        repeat (len) send_request(load_req(1'($urandom_range(0, 1))));
      sweeps = $urandom_range(1, 4);
      repeat (sweeps) begin
        a_odds = $urandom_range(0, 4);
        b_odds = $urandom_range(0, 4);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0)
            send_request(pras_pkg::in_req_t'(4'($urandom_range(0, 15))));
          else
            send_request(update_req($urandom_range(0, 3) < a_odds,
                                    $urandom_range(0, 3) < b_odds));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main_sequence
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_length();
    test_small_ring_rules();
    test_result_backpressure();
    test_random_sweeps();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_stats.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stats.size() != 0) begin
      $display("%0t: %0d generation results expected but never delivered",
               $time, expected_stats.size());
      fail_count++;
    end
    $display("summary: %0d requests, %0d generation results compared", items_sent,
             results_seen);
    $display("summary: loads at full length, rings of 3 to 64 cells, both rules, long output hold");
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/pras_pkg.sv
rtl/pras_rule.sv
rtl/pras_stats.sv
rtl/probabilistic_ring_automaton_step.sv
sim/testbench.sv
